@@ rtl/fcw_pkg.sv @@
package fcw_pkg;

   localparam int FCW_TABLE_BYTES = 16384;

   localparam int ADDR_W    = 14;
   localparam int BYTE_W    = 8;
   localparam int CLUSTER_W = 28;
   localparam int POS_W     = 16;
   localparam int WORD_W    = 32;

   typedef logic [1:0]           fat_kind_type;
   typedef logic [1:0]           status_type;
   typedef logic [CLUSTER_W-1:0] cluster_type;

   localparam fat_kind_type FAT12 = 2'd0;
   localparam fat_kind_type FAT16 = 2'd1;
   localparam fat_kind_type FAT32 = 2'd2;

   localparam status_type ST_FOUND   = 2'd0;
   localparam status_type ST_ENDED   = 2'd1;
   localparam status_type ST_OUTSIDE = 2'd2;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam cluster_type EOC12 = 28'h0000FF8;
   localparam cluster_type EOC16 = 28'h000FFF8;
   localparam cluster_type EOC32 = 28'hFFFFFF8;

   function automatic cluster_type eoc_of(input fat_kind_type kind);
      cluster_type eoc;
      case (kind)
         FAT12:   eoc = EOC12;
         FAT16:   eoc = EOC16;
         default: eoc = EOC32;
      endcase
      return eoc;
   endfunction

endpackage

@@ rtl/fcw_if.sv @@
interface fcw_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [fcw_pkg::ADDR_W-1:0]     byte_address;
   logic [fcw_pkg::BYTE_W-1:0]     byte_value;
   fcw_pkg::cluster_type           chain_head;
   logic [fcw_pkg::POS_W-1:0]      position;

   modport source (output valid, action, byte_address, byte_value, chain_head, position,
                   input ready);
   modport sink   (input valid, action, byte_address, byte_value, chain_head, position,
                   output ready);
endinterface

interface fcw_rsp_if;
   logic                 valid;
   logic                 ready;
   fcw_pkg::cluster_type cluster;
   fcw_pkg::status_type  status;

   modport source (output valid, cluster, status, input ready);
   modport sink   (input valid, cluster, status, output ready);
endinterface

@@ rtl/fat_cluster_chain_walk.sv @@
// FAT cluster chain walker. A load item writes one byte of the table copy
// into a byte-wide single-port-read RAM. A lookup item follows the chain
// from chain_head for position links and returns the cluster reached, or
// status 1 when an end-of-chain marker of the selected FAT type comes
// first, or status 2 when an entry would lie past the table. Each link
// passes through a check state, one RAM read per entry byte and a wait
// state that captures the last byte, paced by the one byte read port.
// Loads keep flowing while a finished result waits on the output
// register. Write fat_type only while idle; table bytes must be loaded
// before a lookup reads them.
module fat_cluster_chain_walk #(
   parameter int TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   fcw_req_if.sink               req_ch,
   fcw_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  fcw_pkg::fat_kind_type csr_wdata
);
   import fcw_pkg::*;

   localparam int AW = $clog2(TABLE_BYTES);

   fat_kind_type      fat_type_ff;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_type_ff <= FAT12;
      end else if (csr_we) begin
         fat_type_ff <= csr_wdata;
      end
   end

   fcw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TABLE_BYTES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   fcw_walker #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .fat_type  (fat_type_ff),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

@@ rtl/fcw_ram.sv @@
module fcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/fcw_walker.sv @@
module fcw_walker #(
   parameter int TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   fcw_req_if.sink                        req_ch,
   fcw_rsp_if.source                      rsp_ch,
   input  fcw_pkg::fat_kind_type          fat_type,
   output logic                           ram_we,
   output logic [$clog2(TABLE_BYTES)-1:0] ram_waddr,
   output logic [fcw_pkg::BYTE_W-1:0]     ram_wdata,
   output logic [$clog2(TABLE_BYTES)-1:0] ram_raddr,
   input  logic [fcw_pkg::BYTE_W-1:0]     ram_rdata
);
   import fcw_pkg::*;

   localparam int AW = $clog2(TABLE_BYTES);
   // highest legal base for a two-byte and a four-byte entry, plus one
   localparam logic [WORD_W-1:0] LIMIT2 = WORD_W'(TABLE_BYTES - 1);
   localparam logic [WORD_W-1:0] LIMIT4 = WORD_W'(TABLE_BYTES - 3);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_WAIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   cluster_type       cl_ff, cl_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  cnt_ff, cnt_in;
   fat_kind_type      kind_ff, kind_in;
   logic [WORD_W-1:0] base_ff, base_in;
   logic              odd_ff, odd_in;
   logic [1:0]        rd_cnt_ff, rd_cnt_in;
   logic              cap_vld_ff, cap_vld_in;
   logic [1:0]        cap_idx_ff, cap_idx_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cluster_type       rsp_cluster_ff, rsp_cluster_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              accept;
   logic [WORD_W-1:0] load_addr;
   logic [WORD_W-1:0] base_calc;
   logic [WORD_W-1:0] limit;
   logic [1:0]        rd_last;
   logic              out_free;
   cluster_type       next_cl;

   assign accept    = req_ch.valid && req_ch.ready;
   assign load_addr = WORD_W'(req_ch.byte_address);

   assign ram_we    = accept && (req_ch.action == ACT_LOAD) &&
                      (load_addr < WORD_W'(TABLE_BYTES));
   assign ram_waddr = load_addr[AW-1:0];
   assign ram_wdata = req_ch.byte_value;
   assign ram_raddr = base_ff[AW-1:0] + AW'(rd_cnt_ff);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rd_last      = (kind_ff == FAT12 || kind_ff == FAT16) ? 2'd1 : 2'd3;
   assign limit        = (kind_ff == FAT12 || kind_ff == FAT16) ? LIMIT2 : LIMIT4;

   // byte offset of the entry for the current cluster
   always_comb begin
      case (kind_ff)
         FAT12:   base_calc = (WORD_W'({cl_ff, 1'b0}) + WORD_W'(cl_ff)) >> 1;
         FAT16:   base_calc = WORD_W'({cl_ff, 1'b0});
         default: base_calc = WORD_W'({cl_ff, 2'b00});
      endcase
   end

   // merge the byte arriving from the RAM into the entry word
   always_comb begin
      acc_in = acc_ff;
      if (cap_vld_ff) begin
         acc_in[8*cap_idx_ff +: 8] = ram_rdata;
      end
   end

   always_comb begin
      case (kind_ff)
         FAT12:   next_cl = odd_ff ? CLUSTER_W'(acc_in[15:4]) : CLUSTER_W'(acc_in[11:0]);
         FAT16:   next_cl = CLUSTER_W'(acc_in[15:0]);
         default: next_cl = acc_in[CLUSTER_W-1:0];
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      cl_in          = cl_ff;
      pos_in         = pos_ff;
      cnt_in         = cnt_ff;
      kind_in        = kind_ff;
      base_in        = base_ff;
      odd_in         = odd_ff;
      rd_cnt_in      = rd_cnt_ff;
      cap_vld_in     = 1'b0;
      cap_idx_in     = cap_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_ch.action == ACT_LOOKUP) begin
               cl_in  = req_ch.chain_head;
               pos_in = req_ch.position;
               cnt_in = '0;
               case (fat_type)
                  FAT12:   kind_in = FAT12;
                  FAT16:   kind_in = FAT16;
                  default: kind_in = FAT32;
               endcase
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (cnt_ff == pos_ff || cl_ff >= eoc_of(kind_ff) || base_calc >= limit) begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (cnt_ff == pos_ff) begin
                     rsp_cluster_in = cl_ff;
                     rsp_status_in  = ST_FOUND;
                  end else if (cl_ff >= eoc_of(kind_ff)) begin
                     rsp_cluster_in = '0;
                     rsp_status_in  = ST_ENDED;
                  end else begin
                     rsp_cluster_in = '0;
                     rsp_status_in  = ST_OUTSIDE;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               base_in   = base_calc;
               odd_in    = cl_ff[0];
               rd_cnt_in = '0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            cap_vld_in = 1'b1;
            cap_idx_in = rd_cnt_ff;
            rd_cnt_in  = rd_cnt_ff + 2'd1;
            if (rd_cnt_ff == rd_last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // last byte lands now: advance one link
            cl_in    = next_cl;
            cnt_in   = cnt_ff + POS_W'(1);
            state_in = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_vld_ff   <= cap_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cl_ff          <= cl_in;
      pos_ff         <= pos_in;
      cnt_ff         <= cnt_in;
      kind_ff        <= kind_in;
      base_ff        <= base_in;
      odd_ff         <= odd_in;
      rd_cnt_ff      <= rd_cnt_in;
      cap_idx_ff     <= cap_idx_in;
      acc_ff         <= acc_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.cluster = rsp_cluster_ff;
   assign rsp_ch.status  = rsp_status_ff;

endmodule
